// ===== src/gcf_pkg.sv =====
// ----------------------------------------------------------------------------
// gcf_pkg
// Shared types, constants and the tanh table of the ground contact force block.
// ----------------------------------------------------------------------------
package gcf_pkg;

  localparam logic [47:0] FORCE_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] FORCE_MIN = 48'h8000_0000_0000;

  typedef enum logic [1:0] {
    REG_STIFFNESS   = 2'd0,
    REG_DISSIPATION = 2'd1,
    REG_FRICTION    = 2'd2,
    REG_SCALE       = 2'd3
  } cfg_reg_t;

  localparam logic [31:0] STIFFNESS_RST   = 32'd50000000;
  localparam logic [23:0] DISSIPATION_RST = 24'd65536;
  localparam logic [19:0] FRICTION_RST    = 20'd65536;
  localparam logic [23:0] SCALE_RST       = 24'd3277;

  typedef struct packed {
    logic [31:0] stiffness;
    logic [23:0] dissipation;
    logic [19:0] friction;
    logic [23:0] scale;
  } cfg_t;

  // round(tanh(k/4) * 2^16), last entry full scale
  function automatic logic [16:0] tanh_tab(input logic [4:0] idx);
    logic [16:0] val;
    case (idx)
      5'd0:    val = 17'd0;
      5'd1:    val = 17'd16051;
      5'd2:    val = 17'd30285;
      5'd3:    val = 17'd41625;
      5'd4:    val = 17'd49912;
      5'd5:    val = 17'd55593;
      5'd6:    val = 17'd59320;
      5'd7:    val = 17'd61694;
      5'd8:    val = 17'd63179;
      5'd9:    val = 17'd64096;
      5'd10:   val = 17'd64659;
      5'd11:   val = 17'd65003;
      5'd12:   val = 17'd65212;
      5'd13:   val = 17'd65339;
      5'd14:   val = 17'd65417;
      5'd15:   val = 17'd65464;
      5'd16:   val = 17'd65492;
      default: val = 17'd65536;
    endcase
    return val;
  endfunction

endpackage

// ===== src/ground_contact_force.sv =====
// ----------------------------------------------------------------------------
// ground_contact_force
// Contact point normal and friction force, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one contact sample per clock unless the output stalls and returns its
// normal and friction force; the pipeline is 17 register stages deep, set by
// the restoring divider of the tanh argument (ten stages of two quotient bits)
// behind the velocity input. When the output is stalled the whole pipeline
// holds and s_tready drops. Configuration writes take effect at once and are
// meant to be made while no item is in flight.
module ground_contact_force import gcf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // [31:0] height, [63:32] vertical_velocity, [95:64] sliding_velocity
  input  logic [95:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // [47:0] normal_force, [95:48] friction_force
  output logic [95:0]  m_tdata,
  // [0] saturated
  output logic [0:0]   m_tuser
);

  localparam int LAT = 17;

  cfg_t        cfg;
  logic        en;
  logic [LAT-1:0] vld;
  logic [47:0] normal, gain_n;
  logic        nsat;
  logic [36:0] gain;
  logic        vneg;
  logic [47:0] normal_force, friction_force;
  logic        saturated;

  assign en       = !vld[LAT-1] || m_tready;
  assign s_tready = en && !rst;
  assign m_tvalid = vld[LAT-1];
  assign m_tdata  = {friction_force, normal_force};
  assign m_tuser  = saturated;
  assign gain_n   = normal;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stiffness   <= STIFFNESS_RST;
      cfg.dissipation <= DISSIPATION_RST;
      cfg.friction    <= FRICTION_RST;
      cfg.scale       <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STIFFNESS:   cfg.stiffness   <= cfg_data;
        REG_DISSIPATION: cfg.dissipation <= cfg_data[23:0];
        REG_FRICTION:    cfg.friction    <= cfg_data[19:0];
        REG_SCALE:       cfg.scale       <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  gcf_spring u_spring (
    .clk               (clk),
    .en                (en),
    .cfg               (cfg),
    .height            (s_tdata[31:0]),
    .vertical_velocity (s_tdata[63:32]),
    .normal            (normal),
    .sat               (nsat)
  );

  gcf_tanh u_tanh (
    .clk              (clk),
    .en               (en),
    .cfg              (cfg),
    .sliding_velocity (s_tdata[95:64]),
    .gain             (gain),
    .vneg             (vneg)
  );

  gcf_friction u_friction (
    .clk            (clk),
    .en             (en),
    .normal         (gain_n),
    .nsat           (nsat),
    .gain           (gain),
    .vneg           (vneg),
    .normal_force   (normal_force),
    .friction_force (friction_force),
    .saturated      (saturated)
  );

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> vld[0])
    else $error("accepted item lost at pipeline entry");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("pipeline moved during stall");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tdata[47:0] == 48'd0)) |-> (m_tdata[95:48] == 48'd0))
    else $error("friction without normal force");

endmodule

// ===== src/gcf_spring.sv =====
// ----------------------------------------------------------------------------
// gcf_spring
// Normal force pipeline: cubic spring-damper term plus void stiffness,
// saturated to 48 bits. Ten register stages.
// ----------------------------------------------------------------------------
module gcf_spring import gcf_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  cfg_t               cfg,
  input  logic signed [31:0] height,
  input  logic signed [31:0] vertical_velocity,
  output logic        [47:0] normal,
  output logic               sat
);

  logic [32:0]  st1_d, st1_r;
  logic [63:0]  st2_dd;
  logic [57:0]  st2_br;
  logic [31:0]  st2_du;
  logic         st2_dpos;
  logic [28:0]  st2_void;
  logic [56:0]  st3_f;
  logic         st3_fp;
  logic [63:0]  st3_pl, st3_ph;
  logic [28:0]  st3_void;
  logic [95:0]  st4_ddd;
  logic [56:0]  st4_f;
  logic         st4_fp;
  logic [28:0]  st4_void;
  logic [63:0]  st5_pk [0:2];
  logic [56:0]  st5_f;
  logic         st5_fp;
  logic [28:0]  st5_void;
  logic [127:0] st6_p3;
  logic [56:0]  st6_f;
  logic         st6_fp;
  logic [28:0]  st6_void;
  logic [63:0]  st7_pp0 [0:3];
  logic [63:0]  st7_pp1 [0:3];
  logic         st7_ovf, st7_fp;
  logic [28:0]  st7_void;
  logic [159:0] st8_slo, st8_shi;
  logic         st8_ovf, st8_fp;
  logic [28:0]  st8_void;
  logic [48:0]  st9_spring;
  logic [28:0]  st9_void;

  logic         dpos;
  logic [58:0]  fsum;
  logic         fpos;
  logic [191:0] qsum;
  logic         qovf;
  logic [49:0]  nsum;

  assign dpos = !st1_d[32] && (st1_d != 33'd0);
  assign fsum = {1'b0, 58'h1_0000_0000} + {st2_br[57], st2_br};
  assign fpos = !fsum[58] && (fsum != 59'd0);
  assign qsum = {32'b0, st8_slo} + {st8_shi, 32'b0};
  assign qovf = st8_ovf || (qsum[191:124] != 68'd0);
  assign nsum = {1'b0, st9_spring} + {{21{st9_void[28]}}, st9_void};

  always_ff @(posedge clk) begin
    if (en) begin
      st1_d <= 33'd0 - {height[31], height};
      st1_r <= 33'd0 - {vertical_velocity[31], vertical_velocity};

      st2_dd   <= {32'b0, st1_d[31:0]} * {32'b0, st1_d[31:0]};
      st2_br   <= {34'b0, cfg.dissipation} * {{25{st1_r[32]}}, st1_r};
      st2_du   <= st1_d[31:0];
      st2_dpos <= dpos;
      st2_void <= {st1_d[32], st1_d[31:4]};

      st3_f    <= fsum[56:0];
      st3_fp   <= st2_dpos && fpos;
      st3_pl   <= {32'b0, st2_dd[31:0]} * {32'b0, st2_du};
      st3_ph   <= {32'b0, st2_dd[63:32]} * {32'b0, st2_du};
      st3_void <= st2_void;

      st4_ddd  <= {32'b0, st3_pl} + {st3_ph, 32'b0};
      st4_f    <= st3_f;
      st4_fp   <= st3_fp;
      st4_void <= st3_void;

      for (int i = 0; i < 3; i++) begin
        st5_pk[i] <= {32'b0, st4_ddd[32*i +: 32]} * {32'b0, cfg.stiffness};
      end
      st5_f    <= st4_f;
      st5_fp   <= st4_fp;
      st5_void <= st4_void;

      st6_p3   <= {64'b0, st5_pk[0]} + {32'b0, st5_pk[1], 32'b0} + {st5_pk[2], 64'b0};
      st6_f    <= st5_f;
      st6_fp   <= st5_fp;
      st6_void <= st5_void;

      for (int j = 0; j < 4; j++) begin
        st7_pp0[j] <= {32'b0, st6_p3[32*j +: 32]} * {32'b0, st6_f[31:0]};
        st7_pp1[j] <= {32'b0, st6_p3[32*j +: 32]} * {39'b0, st6_f[56:32]};
      end
      st7_ovf  <= st6_p3[127:124] != 4'd0;
      st7_fp   <= st6_fp;
      st7_void <= st6_void;

      st8_slo  <= {96'b0, st7_pp0[0]} + {64'b0, st7_pp0[1], 32'b0}
                + {32'b0, st7_pp0[2], 64'b0} + {st7_pp0[3], 96'b0};
      st8_shi  <= {96'b0, st7_pp1[0]} + {64'b0, st7_pp1[1], 32'b0}
                + {32'b0, st7_pp1[2], 64'b0} + {st7_pp1[3], 96'b0};
      st8_ovf  <= st7_ovf;
      st8_fp   <= st7_fp;
      st8_void <= st7_void;

      if (!st8_fp) begin
        st9_spring <= 49'd0;
      end else if (qovf) begin
        st9_spring <= 49'h1_0000_0000_0000;
      end else begin
        st9_spring <= {1'b0, qsum[123:76]};
      end
      st9_void <= st8_void;

      if (!nsum[49] && (nsum[48:47] != 2'b00)) begin
        normal <= FORCE_MAX;
        sat    <= 1'b1;
      end else if (nsum[49] && (nsum[48:47] != 2'b11)) begin
        normal <= FORCE_MIN;
        sat    <= 1'b1;
      end else begin
        normal <= nsum[47:0];
        sat    <= 1'b0;
      end
    end
  end

endmodule

// ===== src/gcf_tanh.sv =====
// ----------------------------------------------------------------------------
// gcf_tanh
// Friction gain pipeline: |v| / scale by a pipelined restoring divider,
// tanh table interpolation, product with the friction coefficient.
// Fifteen register stages.
// ----------------------------------------------------------------------------
module gcf_tanh import gcf_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  cfg_t               cfg,
  input  logic signed [31:0] sliding_velocity,
  output logic        [36:0] gain,
  output logic               vneg
);

  localparam int DIV_STAGES = 10;

  logic [31:0] t1_av;
  logic        t1_neg, t1_zero;

  logic [46:0] drem  [0:DIV_STAGES];
  logic [19:0] dq    [0:DIV_STAGES];
  logic        dfull [0:DIV_STAGES];
  logic        dzero [0:DIV_STAGES];
  logic        dneg  [0:DIV_STAGES];

  logic [16:0] ta_lo;
  logic [15:0] ta_diff;
  logic [13:0] ta_fr;
  logic        ta_big, ta_zero, ta_neg;
  logic [16:0] tb_t;
  logic        tb_neg;

  logic [4:0]  idx;
  logic [16:0] lo, hi;
  logic [29:0] slope;

  always_ff @(posedge clk) begin
    if (en) begin
      t1_av   <= sliding_velocity[31] ? 32'd0 - sliding_velocity : sliding_velocity;
      t1_neg  <= sliding_velocity[31];
      t1_zero <= sliding_velocity == 32'sd0;

      drem[0]  <= {t1_av, 15'b0};
      dq[0]    <= 20'd0;
      dfull[0] <= t1_av >= {4'b0, cfg.scale, 4'b0};
      dzero[0] <= t1_zero;
      dneg[0]  <= t1_neg;
    end
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    localparam int B0 = 19 - 2*g;
    localparam int B1 = 18 - 2*g;
    logic [46:0] nr;
    logic [19:0] nq;
    always_comb begin
      nr = drem[g];
      nq = dq[g];
      if (nr >= ({23'b0, cfg.scale} << B0)) begin
        nr     = nr - ({23'b0, cfg.scale} << B0);
        nq[B0] = 1'b1;
      end
      if (nr >= ({23'b0, cfg.scale} << B1)) begin
        nr     = nr - ({23'b0, cfg.scale} << B1);
        nq[B1] = 1'b1;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        drem[g+1]  <= nr;
        dq[g+1]    <= nq;
        dfull[g+1] <= dfull[g];
        dzero[g+1] <= dzero[g];
        dneg[g+1]  <= dneg[g];
      end
    end
  end

  assign idx   = dq[DIV_STAGES][18:14];
  assign lo    = tanh_tab(idx);
  assign hi    = tanh_tab(5'(idx + 5'd1));
  assign slope = {14'b0, ta_diff} * {16'b0, ta_fr};

  always_ff @(posedge clk) begin
    if (en) begin
      ta_lo   <= lo;
      ta_diff <= 16'(hi - lo);
      ta_fr   <= dq[DIV_STAGES][13:0];
      ta_big  <= dfull[DIV_STAGES] || dq[DIV_STAGES][19] || (idx >= 5'd17);
      ta_zero <= dzero[DIV_STAGES];
      ta_neg  <= dneg[DIV_STAGES];

      if (ta_zero) begin
        tb_t <= 17'd0;
      end else if (ta_big) begin
        tb_t <= 17'd65536;
      end else begin
        tb_t <= ta_lo + {1'b0, slope[29:14]};
      end
      tb_neg <= ta_neg;

      gain <= {20'b0, tb_t} * {17'b0, cfg.friction};
      vneg <= tb_neg;
    end
  end

endmodule

// ===== src/gcf_friction.sv =====
// ----------------------------------------------------------------------------
// gcf_friction
// Aligns the normal force with the friction gain, forms the friction force
// and drives the output register.
// ----------------------------------------------------------------------------
module gcf_friction import gcf_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [47:0] normal,
  input  logic        nsat,
  input  logic [36:0] gain,
  input  logic        vneg,
  output logic [47:0] normal_force,
  output logic [47:0] friction_force,
  output logic        saturated
);

  localparam int DLY = 5;
  localparam logic [52:0] MAG_LIM = 53'h8000_0000_0000;

  logic [47:0] nd   [0:DLY-1];
  logic        sd   [0:DLY-1];

  logic [47:0] an;
  logic [60:0] f1_a, f1_b;
  logic [47:0] f1_n;
  logic        f1_neg, f1_sat;

  logic [84:0] total;
  logic [52:0] mag;

  assign an    = nd[DLY-1][47] ? 48'd0 - nd[DLY-1] : nd[DLY-1];
  assign total = {f1_a, 24'b0} + {24'b0, f1_b};
  assign mag   = total[84:32];

  always_ff @(posedge clk) begin
    if (en) begin
      nd[0] <= normal;
      sd[0] <= nsat;
      for (int i = 1; i < DLY; i++) begin
        nd[i] <= nd[i-1];
        sd[i] <= sd[i-1];
      end

      f1_a   <= {24'b0, gain} * {37'b0, an[47:24]};
      f1_b   <= {24'b0, gain} * {37'b0, an[23:0]};
      f1_n   <= nd[DLY-1];
      f1_neg <= vneg != nd[DLY-1][47];
      f1_sat <= sd[DLY-1];

      normal_force <= f1_n;
      if (f1_neg) begin
        friction_force <= (mag > MAG_LIM) ? FORCE_MIN : 48'd0 - mag[47:0];
        saturated      <= f1_sat || (mag > MAG_LIM);
      end else begin
        friction_force <= (mag >= MAG_LIM) ? FORCE_MAX : mag[47:0];
        saturated      <= f1_sat || (mag >= MAG_LIM);
      end
    end
  end

endmodule

// ===== tb/ground_contact_force_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ground_contact_force_chk
// Watches the ground contact force block's ports and checks every result.
// ----------------------------------------------------------------------------
// Tracks register writes, computes the normal and friction force of each
// accepted contact sample and compares the results in order, field by field.
// Hands the failure count and the number of outstanding results to the top.
module ground_contact_force_chk import gcf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [31:0] height, [63:32] vertical_velocity, [95:64] sliding_velocity
  input  logic [95:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [47:0] normal_force, [95:48] friction_force
  input  logic [95:0] m_tdata,
  // [0] saturated
  input  logic [0:0]  m_tuser,
  output int          errors,
  output int          pending
);

  typedef struct {
    logic [47:0] normal;
    logic [47:0] friction;
    logic        sat;
  } contact_force_t;

  localparam logic signed [63:0] NRM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] NRM_MIN = -NRM_MAX - 64'sd1;
  localparam logic [63:0] MAG_LIM = 64'h0000_8000_0000_0000;
  localparam int unsigned TANH_PTS [18] = '{
    0, 16051, 30285, 41625, 49912, 55593, 59320, 61694, 63179,
    64096, 64659, 65003, 65212, 65339, 65417, 65464, 65492, 65536
  };

  cfg_t cfg;
  contact_force_t expected_forces [$];

  function automatic contact_force_t contact_forces(input logic [95:0] x, input cfg_t c);
    logic signed [63:0] depth, rate, slide, fac, nrm;
    logic [191:0] prod;
    logic [63:0] spring, av, an, xq, ix, frac, t, hi, mag;
    logic [127:0] mprod;
    logic neg;
    contact_force_t res;
    depth = -{{32{x[31]}}, x[31:0]};
    rate  = -{{32{x[63]}}, x[63:32]};
    slide = {{32{x[95]}}, x[95:64]};
    res.sat = 1'b0;
    spring = '0;
    if (depth > 0) begin
      fac = 64'sd4294967296 + $signed({40'd0, c.dissipation}) * rate;
      if (fac > 0) begin
        prod = {160'd0, c.stiffness} * depth * depth * depth * fac;
        if ((prod >> 76) >= 192'h1_0000_0000_0000) spring = 64'h1_0000_0000_0000;
        else spring = {16'd0, prod[123:76]};
      end
    end
    nrm = $signed(spring) + (depth >>> 4);
    if (nrm > NRM_MAX) begin
      nrm = NRM_MAX;
      res.sat = 1'b1;
    end
    if (nrm < NRM_MIN) begin
      nrm = NRM_MIN;
      res.sat = 1'b1;
    end
    av = (slide < 0) ? -slide : slide;
    an = (nrm < 0) ? -nrm : nrm;
    if (av == 0) t = 0;
    else if (c.scale == 0) t = 65536;
    else begin
      xq = (av << 15) / {40'd0, c.scale};
      ix = xq >> 14;
      if (ix >= 17) t = 65536;
      else begin
        frac = {50'd0, xq[13:0]};
        t = TANH_PTS[ix] + (((TANH_PTS[ix + 1] - TANH_PTS[ix]) * frac) >> 14);
      end
    end
    mprod = {64'd0, t} * {108'd0, c.friction} * {64'd0, an};
    hi = mprod[95:32];
    neg = (slide < 0) != (nrm < 0);
    if (neg) begin
      if (hi > MAG_LIM) res.sat = 1'b1;
      mag = (hi > MAG_LIM) ? MAG_LIM : hi;
      mag = -mag;
    end else begin
      mag = hi;
      if (hi > MAG_LIM - 1) begin
        mag = MAG_LIM - 1;
        res.sat = 1'b1;
      end
    end
    res.normal = nrm[47:0];
    res.friction = mag[47:0];
    return res;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    contact_force_t exp_f;
    if (rst) begin
      cfg <= '{STIFFNESS_RST, DISSIPATION_RST, FRICTION_RST, SCALE_RST};
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_STIFFNESS:   cfg.stiffness   <= cfg_data;
          REG_DISSIPATION: cfg.dissipation <= cfg_data[23:0];
          REG_FRICTION:    cfg.friction    <= cfg_data[19:0];
          REG_SCALE:       cfg.scale       <= cfg_data[23:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) expected_forces.push_back(contact_forces(s_tdata, cfg));
      if (m_tvalid && m_tready) begin
        if (expected_forces.size() == 0) begin
          $display("%0t: unexpected item normal=%h friction=%h sat=%b",
                   $time, m_tdata[47:0], m_tdata[95:48], m_tuser[0]);
          errors++;
        end else begin
          exp_f = expected_forces.pop_front();
          if (m_tdata[47:0] !== exp_f.normal) begin
            $display("%0t: normal_force expected %h actual %h",
                     $time, exp_f.normal, m_tdata[47:0]);
            errors++;
          end
          if (m_tdata[95:48] !== exp_f.friction) begin
            $display("%0t: friction_force expected %h actual %h",
                     $time, exp_f.friction, m_tdata[95:48]);
            errors++;
          end
          if (m_tuser[0] !== exp_f.sat) begin
            $display("%0t: saturated expected %b actual %b",
                     $time, exp_f.sat, m_tuser[0]);
            errors++;
          end
        end
      end
      pending <= expected_forces.size();
    end
  end

endmodule

// ===== tb/ground_contact_force_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ground_contact_force_tb
// Stimulus and verdict for the ground contact force block.
// ----------------------------------------------------------------------------
// Runs directed contact samples at the extremes, then random samples under
// several register settings, with random gaps on both streams, one long
// output stall that backs up the pipeline, and idle drains between settings.
module ground_contact_force_tb;
  import gcf_pkg::*;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [95:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;
  logic [0:0]  m_tuser;
  int          errors;
  int          pending;
  bit          hold_rx;

  ground_contact_force u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  ground_contact_force_chk u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] pick_height();
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1, 2:    return $urandom_range(0, 4096);
      3:       return -$urandom_range(0, 1 << 22);
      default: return -$urandom_range(0, 1 << 16);
    endcase
  endfunction

  function automatic logic [31:0] pick_vert();
    if ($urandom_range(0, 4) == 0) return $urandom;
    return $urandom_range(0, 1 << 19) - (1 << 18);
  endfunction

  function automatic logic [31:0] pick_slide();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom;
      2:       return 0;
      default: return $urandom_range(0, 1 << 17) - (1 << 16);
    endcase
  endfunction

  // receiver: random ready, with one long hold on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
      end else if ($urandom_range(0, 99) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  task automatic send(input logic [31:0] h, input logic [31:0] vv, input logic [31:0] sv,
                      input bit gaps);
    int unsigned g;
    s_tvalid <= 1'b1;
    s_tdata  <= {sv, vv, h};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_regs(input cfg_t c);
    cfg_we <= 1'b1; cfg_index <= REG_STIFFNESS;   cfg_data <= c.stiffness;
    @(posedge clk);
    cfg_index <= REG_DISSIPATION; cfg_data <= {8'd0, c.dissipation};
    @(posedge clk);
    cfg_index <= REG_FRICTION;    cfg_data <= {12'd0, c.friction};
    @(posedge clk);
    cfg_index <= REG_SCALE;       cfg_data <= {8'd0, c.scale};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send(32'd0, 32'd0, 32'd0, 0);
    send(32'hFFFF_FFFF, 32'd0, 32'd1, 0);
    send(32'd1, 32'd0, 32'hFFFF_FFFF, 0);
    send(32'hFFFF_FFF0, 32'd0, 32'd100, 0);
    send(32'hFFFF_FFEF, 32'd0, 32'd0, 0);
    send(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 0);
    send(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0);
    send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
    send(32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 0);
    send(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 0);
    send(-32'd4000, 32'h7FFF_FFFF, 32'd5000, 0);
    send(-32'd4000, -32'd65536, -32'd5000, 0);
    send(-32'd4000, 32'd65536, 32'd3277, 0);
    send(-32'd20000, 32'd0, 32'd6554, 1);
    send(-32'd20000, 32'd0, -32'd27853, 1);
    send(-32'd20000, 32'd0, 32'd27854, 1);
    send(-32'd2000000, 32'd0, 32'd1000, 1);
    send(-32'd200000, -32'd1000000, -32'd1000, 1);
    send(32'd4096, 32'd12345, -32'd200, 1);
    send(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1);
    send(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1);
  endtask

  initial begin
    cfg_t c;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_STIFFNESS;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    hold_rx = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    for (int p = 1; p <= 7; p++) begin
      drain();
      case (p)
        1: c = '{32'hFFFF_FFFF, 24'hFF_FFFF, 20'hF_FFFF, 24'hFF_FFFF};
        2: c = '{32'd0, 24'd0, 20'd0, 24'd1};
        3: c = '{STIFFNESS_RST, DISSIPATION_RST, FRICTION_RST, SCALE_RST};
        default: begin
          c.stiffness   = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200000000);
          c.dissipation = $urandom_range(0, 24'hFF_FFFF);
          c.friction    = $urandom_range(0, 20'hF_FFFF);
          c.scale       = $urandom_range(0, 1) ? $urandom_range(1, 24'hFF_FFFF)
                                               : $urandom_range(1, 1 << 16);
        end
      endcase
      write_regs(c);
      if (p == 3) hold_rx = 1'b1;
      if (p <= 3) run_directed();
      for (int i = 0; i < 120; i++) send(pick_height(), pick_vert(), pick_slide(), 1);
    end
    drain();
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/gcf_pkg.sv
src/gcf_spring.sv
src/gcf_tanh.sv
src/gcf_friction.sv
src/ground_contact_force.sv
tb/ground_contact_force_chk.sv
tb/ground_contact_force_tb.sv
